FILE: hdl/mslf_pkg.sv
`default_nettype none

package mslf_pkg;

  // Header layout: sync word, then big-endian priority and length
  localparam int HEADER_BYTES = 16;
  localparam int SYNC_BYTES   = 8;
  localparam int WIN_CNT_W    = $clog2(HEADER_BYTES);

  // "MAGICPIE", first byte in the top bits
  localparam logic [8*SYNC_BYTES-1:0] SYNC_WORD = 64'h4D41_4749_4350_4945;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65535;
  localparam int          QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [31:0] prio;
    logic [31:0] len;
    logic        last;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } qwr_t;

endpackage

`default_nettype wire

FILE: hdl/mslf_front.sv
`default_nettype none

module mslf_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                space_i,
  output mslf_pkg::qwr_t           wr_o
);

  localparam logic [mslf_pkg::WIN_CNT_W-1:0] LAST_COUNT =
    mslf_pkg::WIN_CNT_W'(mslf_pkg::HEADER_BYTES - 1);
  localparam int PRIO_POS = mslf_pkg::SYNC_BYTES + 1;
  localparam int LEN_POS  = mslf_pkg::SYNC_BYTES + 5;

  logic [31:0]                   max_len_q;
  logic [7:0]                    win_q [mslf_pkg::HEADER_BYTES];
  logic [mslf_pkg::WIN_CNT_W-1:0] count_q, count_d;
  logic                          in_payload_q, in_payload_d;
  logic [31:0]                   bytes_left_q, bytes_left_d;
  logic [31:0]                   held_prio_q, held_prio_d;
  logic [31:0]                   held_len_q, held_len_d;
  logic                          acc;
  logic                          sync_hit;
  logic [31:0]                   hdr_prio;
  logic [31:0]                   hdr_len;

  assign in_ready_o = space_i;
  assign acc        = in_valid_i & space_i;

  // Compare the window as it stands after this word shifts in
  always_comb begin
    sync_hit = 1'b1;
    for (int i = 0; i < mslf_pkg::SYNC_BYTES; i++) begin
      if (win_q[i+1] != mslf_pkg::SYNC_WORD[8*(mslf_pkg::SYNC_BYTES-1-i) +: 8]) begin
        sync_hit = 1'b0;
      end
    end
  end

  assign hdr_prio = {win_q[PRIO_POS], win_q[PRIO_POS+1], win_q[PRIO_POS+2],
                     win_q[PRIO_POS+3]};
  assign hdr_len  = {win_q[LEN_POS], win_q[LEN_POS+1], win_q[LEN_POS+2], data_byte_i};

  // Classify the word and pick the next control state
  always_comb begin
    count_d      = count_q;
    in_payload_d = in_payload_q;
    bytes_left_d = bytes_left_q;
    held_prio_d  = held_prio_q;
    held_len_d   = held_len_q;
    wr_o.push     = 1'b0;
    wr_o.res.kind = mslf_pkg::KIND_PAYLOAD;
    wr_o.res.data = data_byte_i;
    wr_o.res.prio = held_prio_q;
    wr_o.res.len  = held_len_q;
    wr_o.res.last = 1'b0;
    if (acc) begin
      if (in_payload_q) begin
        wr_o.push = 1'b1;
        if (bytes_left_q <= 32'd1) begin
          wr_o.res.last = 1'b1;
          in_payload_d  = 1'b0;
          bytes_left_d  = '0;
          count_d       = '0;
        end else begin
          bytes_left_d = bytes_left_q - 32'd1;
        end
      end else if (count_q != LAST_COUNT) begin
        count_d = count_q + 1'b1;
      end else if (sync_hit) begin
        held_prio_d   = hdr_prio;
        held_len_d    = hdr_len;
        wr_o.res.prio = hdr_prio;
        wr_o.res.len  = hdr_len;
        wr_o.res.data = '0;
        if (hdr_len > max_len_q) begin
          // Reject and keep hunting one word on
          wr_o.push     = 1'b1;
          wr_o.res.kind = mslf_pkg::KIND_OVERSIZE;
          wr_o.res.last = 1'b1;
        end else if (hdr_len == 32'd0) begin
          wr_o.push     = 1'b1;
          wr_o.res.kind = mslf_pkg::KIND_EMPTY;
          wr_o.res.last = 1'b1;
          count_d       = '0;
        end else begin
          in_payload_d = 1'b1;
          bytes_left_d = hdr_len;
          count_d      = '0;
        end
      end
    end
  end

  // Hold control state and the length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= mslf_pkg::MAX_LEN_RESET;
      count_q      <= '0;
      in_payload_q <= 1'b0;
      bytes_left_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      count_q      <= count_d;
      in_payload_q <= in_payload_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  // Shift hunt words into the window; latch header fields
  always_ff @(posedge clk_i) begin
    held_prio_q <= held_prio_d;
    held_len_q  <= held_len_d;
    if (acc && !in_payload_q) begin
      for (int i = 0; i < mslf_pkg::HEADER_BYTES - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[mslf_pkg::HEADER_BYTES-1] <= data_byte_i;
    end
  end

  a_no_result_while_filling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !in_payload_q && count_q != LAST_COUNT) |-> !wr_o.push)
    else $error("result pushed before the header window filled");

  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (bytes_left_q != 32'd0))
    else $error("payload mode with no bytes left");

  a_enter_payload_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_payload_q) |-> (count_q == '0))
    else $error("payload started without clearing the window count");

  a_push_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.push |-> space_i)
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire

FILE: hdl/mslf_back.sv
`default_nettype none

module mslf_back #(
  parameter int DEPTH = mslf_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mslf_pkg::qwr_t wr_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mslf_pkg::res_t      res_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mslf_pkg::res_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign space_o     = (cnt_q != CNT_FULL);
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;
  assign res_o       = mem_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    case ({wr_i.push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i.push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // Store results
  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= wr_i.res;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("queue count beyond depth");

  a_stalled_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(rd_ptr_q)))
    else $error("queue head moved while stalled");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.push |-> (cnt_q != CNT_FULL))
    else $error("word written into a full queue");

endmodule

`default_nettype wire

FILE: hdl/magic_sync_length_deframer_top.sv
`default_nettype none

// Sync-word, length-prefixed deframer.
// Input channel (in_valid_i/in_ready_o) carries one stream word per beat.
// While hunting, the last 16 words form a header window; when its first
// 8 words read "MAGICPIE" the next 4 give a big-endian priority and the
// last 4 a big-endian payload length. The following payload words come
// out one per beat, tagged with priority and length, last_o on the final.
// A zero length gives one empty result; a length above the limit written
// through cfg_we_i/cfg_wdata_i (65535 after reset) gives one reject result
// and hunting resumes one word on.
// Throughput is one word per cycle while the result queue has room. Each
// result is registered into a 2-entry result queue that sits between the
// classifier and the output port; the classifier stalls only when that
// queue is full, so a stalled receiver holds off input after the queue
// fills and nothing is lost.
// Reset empties the window and the queue and restores the length limit.
module magic_sync_length_deframer_top #(
  parameter int QUEUE_DEPTH = mslf_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [31:0]      priority_res_o,
  output logic [31:0]      message_length_o,
  output logic             last_o
);

  mslf_pkg::qwr_t wr;
  mslf_pkg::res_t res;
  logic           space;

  mslf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .space_i     (space),
    .wr_o        (wr)
  );

  mslf_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o           = res.kind;
  assign out_byte_o       = res.data;
  assign priority_res_o   = res.prio;
  assign message_length_o = res.len;
  assign last_o           = res.last;

endmodule

`default_nettype wire

FILE: bench/tb_magic_sync_length_deframer_top.sv
`default_nettype none

module tb_magic_sync_length_deframer_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned PHASE_WORDS = 160;
  localparam int unsigned DIR_ROWS    = 7;
  localparam int unsigned MAX_RAND_LEN = 12;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  // Receiver stall patterns
  localparam int unsigned RX_OPEN   = 0;
  localparam int unsigned RX_THIRD  = 1;
  localparam int unsigned RX_COIN   = 2;
  localparam int unsigned RX_SPARSE = 3;

  // One message on the wire: optional leading junk, a header (maybe cut short
  // or with a bad sync word) and its payload; want is typed in where obvious
  typedef struct packed {
    logic [2:0]     lead;
    logic [7:0]     lead_byte;
    logic           bad_sync;
    logic [4:0]     cut;
    logic [31:0]    prio;
    logic [31:0]    len;
    logic [7:0]     npay;
    logic [7:0]     fill;
    logic           typed;
    mslf_pkg::res_t want;
  } frame_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [31:0] priority_res_o;
  logic [31:0] message_length_o;
  logic        last_o;

  // Deframer state as seen by the checker
  logic [7:0]  hunt_win [mslf_pkg::HEADER_BYTES];
  int unsigned hunt_cnt  = 0;
  bit          in_pay    = 1'b0;
  logic [31:0] pay_left  = '0;
  logic [31:0] hold_prio = '0;
  logic [31:0] hold_len  = '0;
  logic [31:0] len_limit = mslf_pkg::MAX_LEN_RESET;

  mslf_pkg::res_t result_q [$];
  int unsigned fails     = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  bit          in_fire   = 1'b0;
  bit          hold_req  = 1'b0;
  bit          broken_ok = 1'b0;

  magic_sync_length_deframer_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .priority_res_o   (priority_res_o),
    .message_length_o (message_length_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < mslf_pkg::HEADER_BYTES; i++) hunt_win[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Drop the oldest window word and leave room for one more
  function automatic void slide_hunt();
    for (int i = 0; i < mslf_pkg::HEADER_BYTES - 1; i++) hunt_win[i] = hunt_win[i + 1];
    hunt_win[mslf_pkg::HEADER_BYTES - 1] = '0;
    hunt_cnt = mslf_pkg::HEADER_BYTES - 1;
  endfunction

  // Advance the deframer by one stream word; return 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output mslf_pkg::res_t r);
    bit sync_hit;
    r = '0;
    if (in_pay) begin
      r = '{mslf_pkg::KIND_PAYLOAD, b, hold_prio, hold_len, (pay_left <= 32'd1)};
      if (pay_left <= 32'd1) begin
        pay_left = '0;
        in_pay = 1'b0;
        hunt_cnt = 0;
      end else begin
        pay_left--;
      end
      return 1'b1;
    end
    if (hunt_cnt >= mslf_pkg::HEADER_BYTES) slide_hunt();
    hunt_win[hunt_cnt] = b;
    hunt_cnt++;
    if (hunt_cnt < mslf_pkg::HEADER_BYTES) return 1'b0;
    sync_hit = 1'b1;
    for (int i = 0; i < mslf_pkg::SYNC_BYTES; i++) begin
      if (hunt_win[i] != mslf_pkg::SYNC_WORD[8*(mslf_pkg::SYNC_BYTES-1-i) +: 8]) begin
        sync_hit = 1'b0;
      end
    end
    if (!sync_hit) begin
      slide_hunt();
      return 1'b0;
    end
    hold_prio = {hunt_win[8], hunt_win[9], hunt_win[10], hunt_win[11]};
    hold_len  = {hunt_win[12], hunt_win[13], hunt_win[14], hunt_win[15]};
    if (hold_len > len_limit) begin
      r = '{mslf_pkg::KIND_OVERSIZE, 8'h00, hold_prio, hold_len, 1'b1};
      slide_hunt();
      return 1'b1;
    end
    if (hold_len == 32'd0) begin
      r = '{mslf_pkg::KIND_EMPTY, 8'h00, hold_prio, hold_len, 1'b1};
      hunt_cnt = 0;
      return 1'b1;
    end
    in_pay = 1'b1;
    pay_left = hold_len;
    hunt_cnt = 0;
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // Sample handshakes at the falling edge before the edge that completes them
  always @(negedge clk_i) begin : result_check
    mslf_pkg::res_t want;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $error("result with none expected: kind %0d, out_byte %0h", kind_o, out_byte_o);
        fails++;
      end else begin
        want = result_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("out_byte", 32'(want.data), 32'(out_byte_o));
        check_field("priority_res", want.prio, priority_res_o);
        check_field("message_length", want.len, message_length_o);
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // Receiver: switch between stall patterns, with one long hold-off on request
  initial begin : rx_side
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    tick = 0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      mode = $urandom_range(RX_OPEN, RX_SPARSE);
      span = $urandom_range(4, 64);
      repeat (span) begin
        tick++;
        case (mode)
          RX_OPEN:  out_ready_i <= 1'b1;
          RX_THIRD: out_ready_i <= ((tick % 3) == 0);
          RX_COIN:  out_ready_i <= 1'($urandom_range(0, 1));
          default:  out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offer one word in bursts with random gaps; predict once it is taken
  task automatic send_byte(input logic [7:0] b, input bit typed, input mslf_pkg::res_t want);
    int unsigned gap;
    bit got;
    mslf_pkg::res_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    data_byte_i <= b;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_fire);
    got = deframe_byte(b, r);
    if (typed) result_q.push_back(want);
    else if (got) result_q.push_back(r);
  endtask

  task automatic send_frame(input frame_t f);
    logic [7:0] hdr [mslf_pkg::HEADER_BYTES];
    mslf_pkg::res_t none;
    none = '0;
    for (int i = 0; i < mslf_pkg::SYNC_BYTES; i++) begin
      hdr[i] = mslf_pkg::SYNC_WORD[8*(mslf_pkg::SYNC_BYTES-1-i) +: 8];
    end
    if (f.bad_sync) begin
      hdr[mslf_pkg::SYNC_BYTES-1] = hdr[mslf_pkg::SYNC_BYTES-1] ^ 8'h01;
    end
    for (int i = 0; i < 4; i++) begin
      hdr[mslf_pkg::SYNC_BYTES + i]     = f.prio[8*(3-i) +: 8];
      hdr[mslf_pkg::SYNC_BYTES + 4 + i] = f.len[8*(3-i) +: 8];
    end
    for (int i = 0; i < f.lead; i++) send_byte(f.lead_byte, 1'b0, none);
    for (int i = 0; i < f.cut; i++) begin
      send_byte(hdr[i], f.typed && (i == mslf_pkg::HEADER_BYTES - 1), f.want);
    end
    for (int i = 0; i < f.npay; i++) send_byte(f.fill + 8'(i * 37), 1'b0, none);
  endtask

  // Mostly good messages sized to the current limit, some junk and broken headers
  task automatic random_frame(output int unsigned used);
    frame_t f;
    int unsigned pick;
    longint unsigned room;
    f = '0;
    f.cut  = 5'(mslf_pkg::HEADER_BYTES);
    f.prio = $urandom;
    f.fill = 8'($urandom);
    room = 64'hFFFF_FFFF - len_limit;
    if ($urandom_range(0, 99) < 15) begin
      f.lead = 3'($urandom_range(1, 6));
      f.lead_byte = $urandom_range(0, 1) ? mslf_pkg::SYNC_WORD[63:56] : 8'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 10 && broken_ok) begin
      // cut short: top length bit set so a false match is mostly rejected
      f.cut = 5'($urandom_range(mslf_pkg::SYNC_BYTES, mslf_pkg::HEADER_BYTES - 1));
      f.len = $urandom | 32'h8000_0000;
    end else if (pick < 16 && broken_ok) begin
      f.bad_sync = 1'b1;
      f.len = $urandom_range(1, MAX_RAND_LEN);
    end else if (pick < 26) begin
      f.len = '0;
    end else if (pick < 40 && room != 0) begin
      f.len = (pick < 30) ? len_limit + 32'd1
                          : 32'(len_limit + 32'd1 + $urandom_range(0, 32'(room - 1)));
    end else if (len_limit != 0) begin
      if (pick >= 95 && len_limit <= 16) f.len = len_limit;
      else f.len = $urandom_range(1, (len_limit < MAX_RAND_LEN) ? len_limit : MAX_RAND_LEN);
      f.npay = 8'(f.len);
    end
    send_frame(f);
    used = f.cut + f.npay;
  endtask

  // Stop offering and let every expected result come out
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    len_limit = v;
  endtask

  initial begin : stimulus
    frame_t dir_rows [DIR_ROWS];
    logic [31:0] limits [6];
    frame_t f;
    int unsigned used;
    int unsigned phase_words;

    dir_rows = '{
      // empty message right after reset
      '{3'd0, 8'h00, 1'b0, 5'd16, 32'h0000_0000, 32'h0000_0000, 8'd0, 8'h00, 1'b1,
        '{mslf_pkg::KIND_EMPTY, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1}},
      // one above the reset limit
      '{3'd0, 8'h00, 1'b0, 5'd16, 32'hFFFF_FFFF, 32'h0001_0000, 8'd0, 8'h00, 1'b1,
        '{mslf_pkg::KIND_OVERSIZE, 8'h00, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1}},
      // leading sync-like junk, then a sync word off by one bit
      '{3'd3, 8'h4D, 1'b1, 5'd16, 32'h0000_0001, 32'h0000_0001, 8'd0, 8'h00, 1'b0, '0},
      '{3'd0, 8'h00, 1'b0, 5'd16, 32'h8000_0001, 32'h0000_0001, 8'd1, 8'hFF, 1'b0, '0},
      '{3'd2, 8'h00, 1'b0, 5'd16, 32'h0A0B_0C0D, 32'h0000_0003, 8'd3, 8'h00, 1'b0, '0},
      // all-ones length against the reset limit
      '{3'd0, 8'h00, 1'b0, 5'd16, 32'h0000_0007, 32'hFFFF_FFFF, 8'd0, 8'h00, 1'b1,
        '{mslf_pkg::KIND_OVERSIZE, 8'h00, 32'h0000_0007, 32'hFFFF_FFFF, 1'b1}},
      '{3'd0, 8'h00, 1'b0, 5'd16, 32'h5A5A_A5A5, 32'h0000_0002, 8'd2, 8'h80, 1'b0, '0}
    };
    limits = '{32'd0, 32'd1, 32'd5, 32'd16, 32'($urandom_range(17, 32'h00FF_FFFF)),
               32'hFFFF_FFFE};

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) send_frame(dir_rows[i]);
    drain();

    // Random phases, one per limit setting; first one under a long receiver hold
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      broken_ok = (limits[p] != 32'hFFFF_FFFE);
      if (p == 0) hold_req = 1'b1;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        random_frame(used);
        phase_words += used;
      end
      drain();
    end

    // Widest limit: an all-ones length is taken and the run ends mid-payload
    write_limit(ALL_ONES);
    broken_ok = 1'b0;
    repeat (3) random_frame(used);
    f = '0;
    f.cut  = 5'(mslf_pkg::HEADER_BYTES);
    f.prio = $urandom;
    f.len  = ALL_ONES;
    f.npay = 8'd24;
    f.fill = 8'($urandom);
    send_frame(f);
    drain();

    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
